// File: hdl/dst_pkg.sv
// Shared constants and types for the device slot table.
`timescale 1ns / 1ps
`default_nettype none

package dst_pkg;

	// Table geometry
	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);

	// Field widths
	localparam int REQ_W    = 2;
	localparam int ADDR_W   = 48;
	localparam int SLOT_W   = 4;
	localparam int HANDLE_W = 8;
	localparam int ATTR_W   = 16;
	localparam int SUBCL_W  = 8;
	localparam int APP_W    = 8;
	localparam int RES_W    = 5;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_FIND  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAN = 2'd2;

	// Table update broadcast to every cell
	typedef enum logic [1:0] {
		CMT_ALLOC,
		CMT_ADD,
		CMT_CLEAR
	} cmt_op_t;

	typedef struct packed {
		logic             en;
		cmt_op_t          op;
		logic [IDX_W-1:0] idx;
	} cmt_t;

	// Scan token handed from cell to cell
	typedef struct packed {
		logic             vld;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic             free;
		logic [IDX_W-1:0] free_idx;
	} scan_t;

endpackage

`default_nettype wire

// File: hdl/dst_if.sv
// Request and response channel interfaces of the device slot table.
`timescale 1ns / 1ps
`default_nettype none

interface dst_in_if;
	logic                          valid;
	logic                          ready;
	logic [dst_pkg::REQ_W-1:0]     req_type;
	logic [dst_pkg::ADDR_W-1:0]    dev_addr;
	logic [dst_pkg::SLOT_W-1:0]    slot;
	logic [dst_pkg::HANDLE_W-1:0]  dev_handle;
	logic [dst_pkg::ATTR_W-1:0]    attr_bits;
	logic [dst_pkg::SUBCL_W-1:0]   dev_subclass;
	logic [dst_pkg::APP_W-1:0]     application_id;

	modport source (
		output valid, req_type, dev_addr, slot, dev_handle, attr_bits,
		       dev_subclass, application_id,
		input  ready
	);
	modport sink (
		input  valid, req_type, dev_addr, slot, dev_handle, attr_bits,
		       dev_subclass, application_id,
		output ready
	);
endinterface

interface dst_out_if;
	logic                       valid;
	logic                       ready;
	logic [dst_pkg::RES_W-1:0]  slot_result;
	logic                       matched;

	modport source (output valid, slot_result, matched, input ready);
	modport sink (input valid, slot_result, matched, output ready);
endinterface

`default_nettype wire

// File: hdl/dst_cell.sv
// One table entry: address and used flag, plus one step of the lookup scan.
`timescale 1ns / 1ps
`default_nettype none

module dst_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [dst_pkg::IDX_W-1:0]  cell_idx,
	input  wire logic [dst_pkg::ADDR_W-1:0] query,
	input  wire logic                       query_nz,
	input  wire dst_pkg::scan_t             scan_in,
	output dst_pkg::scan_t                  scan_out,
	input  wire dst_pkg::cmt_t              cmt
);
	import dst_pkg::*;

	logic [ADDR_W-1:0] addr_q;
	logic              used_q;
	scan_t             scan_q;
	scan_t             scan_nxt;
	logic              match;

	// Fold this entry into the running first-hit / first-free search
	always_comb begin
		match             = query_nz && (addr_q == query);
		scan_nxt.vld      = scan_in.vld;
		scan_nxt.hit      = scan_in.hit | match;
		scan_nxt.hit_idx  = scan_in.hit ? scan_in.hit_idx : cell_idx;
		scan_nxt.free     = scan_in.free | ~used_q;
		scan_nxt.free_idx = scan_in.free ? scan_in.free_idx : cell_idx;
	end

	// Token register toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q <= scan_nxt;
		end
	end

	assign scan_out = scan_q;

	// Entry contents, updated by the broadcast commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			used_q <= 1'b0;
		end else if (cmt.en && (cmt.idx == cell_idx)) begin
			case (cmt.op)
				CMT_ALLOC: begin
					addr_q <= query;
				end
				CMT_ADD: begin
					used_q <= 1'b1;
				end
				CMT_CLEAR: begin
					addr_q <= '0;
					used_q <= 1'b0;
				end
				default: begin
					used_q <= used_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/device_slot_table_core.sv
// Top level of the device slot table: request control, cell chain, result register.
// A find request walks a token once down a chain of ENTRIES cells, one cell per
// clock, collecting the first address hit and the first unused entry; if there
// is no hit, the first unused entry then takes the address, in the same cycle
// that the result is loaded into the output register. A find passes launch_q,
// the cells and fin_q; add, clean up and the unused request code skip the chain.
// One request is in the block at a time; a new request is taken while the
// previous result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module device_slot_table_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dst_in_if.sink     request,
	dst_out_if.source  response
);
	import dst_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic               launch_q;
	logic [REQ_W-1:0]   req_type_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [SLOT_W-1:0]  slot_q;
	scan_t              fin_q;
	logic               out_vld_q;
	logic [RES_W-1:0]   res_q;
	logic               matched_q;

	scan_t              chain [0:ENTRIES];
	logic [ENTRIES-1:0] chain_vld;
	cmt_t               cmt_c;
	logic [RES_W-1:0]   res_c;
	logic               matched_c;
	logic               out_free;
	logic               commit;
	logic               slot_ok;
	logic               query_nz;

	assign request.ready = (state_q == ST_IDLE);
	assign out_free      = !out_vld_q || response.ready;
	assign commit        = (state_q == ST_DONE) && out_free;
	assign query_nz      = |addr_q;
	assign slot_ok       = 32'(slot_q) < 32'(ENTRIES);

	// Token entering the chain
	assign chain[0] = scan_t'{vld: launch_q, default: '0};

	// Row of entry cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		dst_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.query    (addr_q),
			.query_nz (query_nz),
			.scan_in  (chain[i]),
			.scan_out (chain[i+1]),
			.cmt      (cmt_c)
		);
		assign chain_vld[i] = chain[i+1].vld;
	end

	// Result and table update for the finished request
	always_comb begin
		res_c     = RES_W'(slot_q);
		matched_c = 1'b0;
		cmt_c.en  = 1'b0;
		cmt_c.op  = CMT_ALLOC;
		cmt_c.idx = IDX_W'(slot_q);
		case (req_type_q)
			REQ_FIND: begin
				if (fin_q.hit) begin
					res_c     = RES_W'(fin_q.hit_idx);
					matched_c = 1'b1;
				end else if (fin_q.free) begin
					res_c     = RES_W'(fin_q.free_idx);
					cmt_c.en  = commit;
					cmt_c.idx = fin_q.free_idx;
				end else begin
					res_c = RES_W'(ENTRIES);
				end
			end
			REQ_ADD: begin
				cmt_c.en = commit && slot_ok;
				cmt_c.op = CMT_ADD;
			end
			REQ_CLEAN: begin
				cmt_c.en = commit && slot_ok;
				cmt_c.op = CMT_CLEAR;
			end
			default: begin
				cmt_c.en = 1'b0;
			end
		endcase
	end

	// Control state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			launch_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			// token enters the chain in the cycle after a find is taken
			launch_q <= (state_q == ST_IDLE) && request.valid &&
				(request.req_type == REQ_FIND);
			if (commit) begin
				out_vld_q <= 1'b1;
			end else if (response.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (request.valid) begin
						req_type_q <= request.req_type;
						addr_q     <= request.dev_addr;
						slot_q     <= request.slot;
						if (request.req_type == REQ_FIND) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (chain[ENTRIES].vld) begin
						fin_q   <= chain[ENTRIES];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						res_q     <= res_c;
						matched_q <= matched_c;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign response.valid       = out_vld_q;
	assign response.slot_result = res_q;
	assign response.matched     = matched_q;

	// At most one token in the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chain_vld))
		else $error("more than one scan token in the cell chain");

	// Token leaves the chain only while the controller waits for it
	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain[ENTRIES].vld |-> state_q == ST_SCAN)
		else $error("scan token finished outside of a scan");

	// A hit always names a real entry
	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		response.valid && response.matched |-> response.slot_result < RES_W'(ENTRIES))
		else $error("matched result with out-of-range slot");

endmodule

`default_nettype wire
